// ----- rtl/core/crast_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// Circle rasterizer package
// Shared command codes, operation codes and the front-to-back control group.
// ============================================================================
package crast_pkg;

    // Operation codes carried on the input channel.
    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    // Drawing modes.
    localparam logic MODE_OUTLINE = 1'b0;
    localparam logic MODE_FILLED  = 1'b1;

    // Depth of the command queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;

    // Number of symmetric points given by one outline step.
    localparam int OUT_POINTS = 8;

    // Kind of work that one queued command asks of the back.
    typedef enum logic [1:0] {
        CMD_IDLE_STEP,
        CMD_OUTLINE,
        CMD_FILLED
    } cmd_kind_t;

    // Control group that travels with each queued command.
    typedef struct packed {
        cmd_kind_t kind;
        logic      fin;
    } cmd_ctrl_t;

endpackage

// ----- rtl/core/crast_front.sv -----
`timescale 1ns / 1ps
// ============================================================================
// Circle rasterizer front
// Accepts input items, holds the circle state, classifies each step and
// advances the offsets and decision term. Each step becomes one command.
// ============================================================================
module crast_front
    import crast_pkg::*;
#(
    parameter int COORD_BITS  = 12,
    parameter int RADIUS_BITS = 8
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     accept,
    input  logic                     operation,
    input  logic [COORD_BITS-1:0]    center_x,
    input  logic [COORD_BITS-1:0]    center_y,
    input  logic [RADIUS_BITS-1:0]   circle_radius,
    input  logic                     fill_mode,
    output logic                     enq,
    output cmd_ctrl_t                enq_ctrl,
    output logic [COORD_BITS-1:0]    enq_cx,
    output logic [COORD_BITS-1:0]    enq_cy,
    output logic [RADIUS_BITS:0]     enq_a,
    output logic [RADIUS_BITS:0]     enq_b,
    output logic [RADIUS_BITS-1:0]   enq_r
);

    localparam int OFS_BITS = RADIUS_BITS + 1;
    localparam int DT_BITS  = RADIUS_BITS + 3;
    localparam int CALC_BITS = RADIUS_BITS + 4;
    localparam int SCAN_BITS = OFS_BITS + 1;

    logic [COORD_BITS-1:0]  held_cx_reg, held_cx_next;
    logic [COORD_BITS-1:0]  held_cy_reg, held_cy_next;
    logic [RADIUS_BITS-1:0] held_r_reg, held_r_next;
    logic                   held_mode_reg, held_mode_next;
    logic                   busy_reg, busy_next;
    logic [OFS_BITS-1:0]    ofs_a_reg, ofs_a_next;
    logic [OFS_BITS-1:0]    ofs_b_reg, ofs_b_next;
    logic signed [DT_BITS-1:0] dterm_reg, dterm_next;

    logic signed [CALC_BITS-1:0] a_w, b_w, r_w, d_w;
    logic signed [CALC_BITS-1:0] na_w, nb_w, nd_w;
    logic                        out_fin;
    logic [SCAN_BITS-1:0]        w_inc, h_inc, two_r;
    logic                        end_col, fill_fin;

    // The command carries the state as it stands before this step.
    assign enq_cx = held_cx_reg;
    assign enq_cy = held_cy_reg;
    assign enq_a  = ofs_a_reg;
    assign enq_b  = ofs_b_reg;
    assign enq_r  = held_r_reg;

    // Outline decision-term update.
    always_comb
    begin
        a_w = CALC_BITS'(ofs_a_reg);
        b_w = CALC_BITS'(ofs_b_reg);
        r_w = CALC_BITS'(held_r_reg);
        d_w = CALC_BITS'(dterm_reg);
        if (d_w >= (a_w <<< 1))
        begin
            nd_w = CALC_BITS'(d_w - (a_w <<< 1) - 1);
            na_w = CALC_BITS'(a_w + 1);
            nb_w = b_w;
        end
        else if (d_w < ((r_w - b_w) <<< 1))
        begin
            nd_w = CALC_BITS'(d_w + (b_w <<< 1) - 1);
            na_w = a_w;
            nb_w = CALC_BITS'(b_w - 1);
        end
        else
        begin
            nd_w = CALC_BITS'(d_w + ((b_w - a_w - 1) <<< 1));
            na_w = CALC_BITS'(a_w + 1);
            nb_w = CALC_BITS'(b_w - 1);
        end
        out_fin = (nb_w < na_w);
    end

    // Filled scan position: the row index runs fastest.
    always_comb
    begin
        w_inc    = SCAN_BITS'(ofs_a_reg) + SCAN_BITS'(1);
        h_inc    = SCAN_BITS'(ofs_b_reg) + SCAN_BITS'(1);
        two_r    = SCAN_BITS'(held_r_reg) << 1;
        end_col  = (h_inc >= two_r);
        fill_fin = end_col && (w_inc >= two_r);
    end

    // Next state for each accepted item, and the command for each step.
    always_comb
    begin
        held_cx_next   = held_cx_reg;
        held_cy_next   = held_cy_reg;
        held_r_next    = held_r_reg;
        held_mode_next = held_mode_reg;
        busy_next      = busy_reg;
        ofs_a_next     = ofs_a_reg;
        ofs_b_next     = ofs_b_reg;
        dterm_next     = dterm_reg;
        enq            = 1'b0;
        enq_ctrl.kind  = CMD_IDLE_STEP;
        enq_ctrl.fin   = 1'b1;
        if (accept)
        begin
            if (operation == OP_START)
            begin
                held_cx_next   = center_x;
                held_cy_next   = center_y;
                held_r_next    = circle_radius;
                held_mode_next = fill_mode;
                busy_next      = 1'b1;
                ofs_a_next     = '0;
                if (fill_mode == MODE_FILLED)
                begin
                    ofs_b_next = '0;
                    dterm_next = '0;
                end
                else
                begin
                    ofs_b_next = OFS_BITS'(circle_radius);
                    dterm_next = DT_BITS'(circle_radius) - DT_BITS'(1);
                end
            end
            else
            begin
                enq = 1'b1;
                if (!busy_reg)
                begin
                    enq_ctrl.kind = CMD_IDLE_STEP;
                    enq_ctrl.fin  = 1'b1;
                end
                else if (held_mode_reg == MODE_FILLED)
                begin
                    enq_ctrl.kind = CMD_FILLED;
                    enq_ctrl.fin  = fill_fin;
                    busy_next     = !fill_fin;
                    if (!fill_fin)
                    begin
                        if (end_col)
                        begin
                            ofs_a_next = w_inc[OFS_BITS-1:0];
                            ofs_b_next = '0;
                        end
                        else
                        begin
                            ofs_b_next = h_inc[OFS_BITS-1:0];
                        end
                    end
                end
                else
                begin
                    enq_ctrl.kind = CMD_OUTLINE;
                    enq_ctrl.fin  = out_fin;
                    busy_next     = !out_fin;
                    ofs_a_next    = na_w[OFS_BITS-1:0];
                    ofs_b_next    = nb_w[OFS_BITS-1:0];
                    dterm_next    = nd_w[DT_BITS-1:0];
                end
            end
        end
    end

    // Circle state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_cx_reg   <= '0;
            held_cy_reg   <= '0;
            held_r_reg    <= '0;
            held_mode_reg <= 1'b0;
            busy_reg      <= 1'b0;
            ofs_a_reg     <= '0;
            ofs_b_reg     <= '0;
            dterm_reg     <= '0;
        end
        else
        begin
            held_cx_reg   <= held_cx_next;
            held_cy_reg   <= held_cy_next;
            held_r_reg    <= held_r_next;
            held_mode_reg <= held_mode_next;
            busy_reg      <= busy_next;
            ofs_a_reg     <= ofs_a_next;
            ofs_b_reg     <= ofs_b_next;
            dterm_reg     <= dterm_next;
        end
    end

endmodule

// ----- rtl/core/crast_queue.sv -----
`timescale 1ns / 1ps
// ============================================================================
// Circle rasterizer command queue
// A short first-in first-out queue of commands between the front and the
// back, with the oldest entry shown at its head.
// ============================================================================
module crast_queue
    import crast_pkg::*;
#(
    parameter int DATA_BITS = 58
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  cmd_ctrl_t            push_ctrl,
    input  logic [DATA_BITS-1:0] push_data,
    output logic                 full,
    input  logic                 pop,
    output logic                 valid,
    output cmd_ctrl_t            head_ctrl,
    output logic [DATA_BITS-1:0] head_data
);

    localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    cmd_ctrl_t            ctrl_q [QUEUE_DEPTH];
    logic [DATA_BITS-1:0] data_q [QUEUE_DEPTH];
    logic [PTR_BITS-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0]  count_reg, count_next;
    logic                 do_push, do_pop;

    assign full      = (count_reg == CNT_BITS'(QUEUE_DEPTH));
    assign valid     = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && valid;
    assign head_ctrl = ctrl_q[rd_ptr_reg];
    assign head_data = data_q[rd_ptr_reg];

    // Pointer and fill-count bookkeeping.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                    : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                    : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage; written on a push transfer.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            ctrl_q[wr_ptr_reg] <= push_ctrl;
            data_q[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- rtl/core/crast_back.sv -----
`timescale 1ns / 1ps
// ============================================================================
// Circle rasterizer back
// Takes one command at a time from the queue and carries it out: eight
// symmetric outline points, one filled-disc candidate with its distance
// test, or the idle result. Results leave through one output register.
// ============================================================================
module crast_back
    import crast_pkg::*;
#(
    parameter int COORD_BITS  = 12,
    parameter int RADIUS_BITS = 8
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    input  cmd_ctrl_t                     cmd_ctrl,
    input  logic [COORD_BITS-1:0]         cmd_cx,
    input  logic [COORD_BITS-1:0]         cmd_cy,
    input  logic [RADIUS_BITS:0]          cmd_a,
    input  logic [RADIUS_BITS:0]          cmd_b,
    input  logic [RADIUS_BITS-1:0]        cmd_r,
    output logic                          cmd_pop,
    output logic                          empty,
    input  logic                          pop,
    output logic signed [COORD_BITS+1:0]  point_x,
    output logic signed [COORD_BITS+1:0]  point_y,
    output logic                          plot,
    output logic                          last
);

    localparam int OFS_BITS = RADIUS_BITS + 1;
    localparam int PT_BITS  = COORD_BITS + 2;
    localparam int DEL_BITS = RADIUS_BITS + 3;
    localparam int SQ_BITS  = 2 * DEL_BITS;
    localparam int IDX_BITS = $clog2(OUT_POINTS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_OUTLINE,
        ST_SQUARE,
        ST_FILL,
        ST_IDLE_RES
    } back_state_t;

    back_state_t            state_reg;
    logic                   fin_reg;
    logic [COORD_BITS-1:0]  cx_reg, cy_reg;
    logic [OFS_BITS-1:0]    a_reg, b_reg;
    logic [RADIUS_BITS-1:0] r_reg;
    logic [IDX_BITS-1:0]    idx_reg;
    logic signed [DEL_BITS-1:0] dx_reg, dy_reg;
    logic [SQ_BITS-1:0]     sqx_reg, sqy_reg, sqr_reg;
    logic                   out_valid_reg;
    logic [PT_BITS-1:0]     px_reg, py_reg;
    logic                   plot_reg, last_reg;

    logic                       slot_free;
    logic                       out_load;
    logic signed [DEL_BITS-1:0] dx_c, dy_c;
    logic signed [SQ_BITS-1:0]  sqx_c, sqy_c;
    logic [SQ_BITS-1:0]         sqr_c;
    logic [SQ_BITS:0]           dist_sum;
    logic                       inside_c;
    logic [OFS_BITS-1:0]        ox, oy;
    logic signed [31:0]         ox_w, oy_w, cx_w, cy_w, px_w, py_w, fx_w, fy_w;

    assign slot_free = !out_valid_reg || pop;
    assign empty     = !out_valid_reg;
    assign point_x   = px_reg;
    assign point_y   = py_reg;
    assign plot      = plot_reg;
    assign last      = last_reg;
    assign cmd_pop   = (state_reg == ST_IDLE) && cmd_valid;

    // A new result enters the output register in every result state with room.
    assign out_load  = slot_free &&
                       (state_reg inside {ST_OUTLINE, ST_FILL, ST_IDLE_RES});

    // Outline point for the current index: bit 0 swaps the offsets,
    // bit 1 negates the column offset, bit 2 negates the row offset.
    always_comb
    begin
        ox   = idx_reg[0] ? b_reg : a_reg;
        oy   = idx_reg[0] ? a_reg : b_reg;
        ox_w = 32'(ox);
        oy_w = 32'(oy);
        cx_w = 32'(cx_reg);
        cy_w = 32'(cy_reg);
        px_w = idx_reg[1] ? cx_w - ox_w : cx_w + ox_w;
        py_w = idx_reg[2] ? cy_w - oy_w : cy_w + oy_w;
    end

    // Filled candidate offsets and their squares.
    always_comb
    begin
        dx_c  = DEL_BITS'(r_reg) - DEL_BITS'(a_reg);
        dy_c  = DEL_BITS'(r_reg) - DEL_BITS'(b_reg);
        sqx_c = dx_c * dx_c;
        sqy_c = dy_c * dy_c;
        sqr_c = SQ_BITS'(r_reg) * SQ_BITS'(r_reg);
    end

    // Distance test and candidate position from the registered squares.
    always_comb
    begin
        dist_sum = (SQ_BITS + 1)'(sqx_reg) + (SQ_BITS + 1)'(sqy_reg);
        inside_c = (dist_sum <= (SQ_BITS + 1)'(sqr_reg));
        fx_w     = 32'(cx_reg) + 32'(dx_reg);
        fy_w     = 32'(cy_reg) + 32'(dy_reg);
    end

    // Sequencer with the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fin_reg       <= 1'b0;
            cx_reg        <= '0;
            cy_reg        <= '0;
            a_reg         <= '0;
            b_reg         <= '0;
            r_reg         <= '0;
            idx_reg       <= '0;
            dx_reg        <= '0;
            dy_reg        <= '0;
            sqx_reg       <= '0;
            sqy_reg       <= '0;
            sqr_reg       <= '0;
            out_valid_reg <= 1'b0;
            px_reg        <= '0;
            py_reg        <= '0;
            plot_reg      <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            // The output register fills on a load and empties on a pop transfer.
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop && out_valid_reg)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        fin_reg <= cmd_ctrl.fin;
                        cx_reg  <= cmd_cx;
                        cy_reg  <= cmd_cy;
                        a_reg   <= cmd_a;
                        b_reg   <= cmd_b;
                        r_reg   <= cmd_r;
                        idx_reg <= '0;
                        case (cmd_ctrl.kind)
                            CMD_OUTLINE: state_reg <= ST_OUTLINE;
                            CMD_FILLED:  state_reg <= ST_SQUARE;
                            default:     state_reg <= ST_IDLE_RES;
                        endcase
                    end
                end
                ST_OUTLINE:
                begin
                    if (slot_free)
                    begin
                        px_reg        <= px_w[PT_BITS-1:0];
                        py_reg        <= py_w[PT_BITS-1:0];
                        plot_reg      <= 1'b1;
                        last_reg      <= fin_reg && (idx_reg == IDX_BITS'(OUT_POINTS - 1));
                        idx_reg       <= idx_reg + 1'b1;
                        if (idx_reg == IDX_BITS'(OUT_POINTS - 1))
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                ST_SQUARE:
                begin
                    dx_reg    <= dx_c;
                    dy_reg    <= dy_c;
                    sqx_reg   <= sqx_c;
                    sqy_reg   <= sqy_c;
                    sqr_reg   <= sqr_c;
                    state_reg <= ST_FILL;
                end
                ST_FILL:
                begin
                    if (slot_free)
                    begin
                        px_reg        <= fx_w[PT_BITS-1:0];
                        py_reg        <= fy_w[PT_BITS-1:0];
                        plot_reg      <= inside_c;
                        last_reg      <= fin_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                ST_IDLE_RES:
                begin
                    if (slot_free)
                    begin
                        px_reg        <= '0;
                        py_reg        <= '0;
                        plot_reg      <= 1'b0;
                        last_reg      <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- rtl/core/circle_rasterizer_unit.sv -----
`timescale 1ns / 1ps
// ============================================================================
// Circle rasterizer unit
// Draws circle outlines by the integer decision-term method and filled discs
// by a square scan with a distance test, one step item at a time.
//
//   Channel   Handshake      Payload
//   input     push / full    operation, center_x, center_y, circle_radius,
//                            fill_mode
//   result    pop / empty    point_x, point_y, plot, last
//
// A start item gives no result. In the back an outline step passes through
// a fetch of the command and then eight points, one per cycle while the
// output register has room; a filled step passes through fetch, square and
// distance test; a step while idle passes through fetch and the idle result.
// The front classifies and updates the circle state in the cycle of the
// transfer; a two-entry command queue lets it run ahead of the back.
// Reset leaves the unit idle with an empty queue and no waiting result.
// While pop stays low the back holds its result and the queue fills,
// after which full holds off further input.
// ============================================================================
module circle_rasterizer_unit
    import crast_pkg::*;
#(
    parameter int COORD_BITS  = 12,
    parameter int RADIUS_BITS = 8
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic                          operation,
    input  logic [COORD_BITS-1:0]         center_x,
    input  logic [COORD_BITS-1:0]         center_y,
    input  logic [RADIUS_BITS-1:0]        circle_radius,
    input  logic                          fill_mode,
    output logic                          empty,
    input  logic                          pop,
    output logic signed [COORD_BITS+1:0]  point_x,
    output logic signed [COORD_BITS+1:0]  point_y,
    output logic                          plot,
    output logic                          last
);

    localparam int OFS_BITS  = RADIUS_BITS + 1;
    localparam int DATA_BITS = 2 * COORD_BITS + 2 * OFS_BITS + RADIUS_BITS;

    logic                   accept;
    logic                   enq;
    cmd_ctrl_t              enq_ctrl;
    logic [COORD_BITS-1:0]  enq_cx, enq_cy;
    logic [OFS_BITS-1:0]    enq_a, enq_b;
    logic [RADIUS_BITS-1:0] enq_r;
    logic [DATA_BITS-1:0]   enq_data;
    logic                   q_full, q_valid, q_pop;
    cmd_ctrl_t              head_ctrl;
    logic [DATA_BITS-1:0]   head_data;
    logic [COORD_BITS-1:0]  head_cx, head_cy;
    logic [OFS_BITS-1:0]    head_a, head_b;
    logic [RADIUS_BITS-1:0] head_r;

    // An input transfer needs room for the command it may queue.
    assign full   = q_full;
    assign accept = push && !q_full;

    // Command payload packing for the queue.
    assign enq_data = {enq_cx, enq_cy, enq_a, enq_b, enq_r};
    assign {head_cx, head_cy, head_a, head_b, head_r} = head_data;

    crast_front #(
        .COORD_BITS  (COORD_BITS),
        .RADIUS_BITS (RADIUS_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .operation     (operation),
        .center_x      (center_x),
        .center_y      (center_y),
        .circle_radius (circle_radius),
        .fill_mode     (fill_mode),
        .enq           (enq),
        .enq_ctrl      (enq_ctrl),
        .enq_cx        (enq_cx),
        .enq_cy        (enq_cy),
        .enq_a         (enq_a),
        .enq_b         (enq_b),
        .enq_r         (enq_r)
    );

    crast_queue #(
        .DATA_BITS (DATA_BITS)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (enq),
        .push_ctrl (enq_ctrl),
        .push_data (enq_data),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .head_ctrl (head_ctrl),
        .head_data (head_data)
    );

    crast_back #(
        .COORD_BITS  (COORD_BITS),
        .RADIUS_BITS (RADIUS_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_valid),
        .cmd_ctrl  (head_ctrl),
        .cmd_cx    (head_cx),
        .cmd_cy    (head_cy),
        .cmd_a     (head_a),
        .cmd_b     (head_b),
        .cmd_r     (head_r),
        .cmd_pop   (q_pop),
        .empty     (empty),
        .pop       (pop),
        .point_x   (point_x),
        .point_y   (point_y),
        .plot      (plot),
        .last      (last)
    );

endmodule

// ----- test/circle_rasterizer_unit_test.sv -----
`timescale 1ns / 1ps
// ============================================================================
// Circle rasterizer unit testbench
// Sends start and step items through the input queue port and predicts every
// point that the unit should return, outline and filled, idle steps and
// restarts included. Each point popped from the result port is compared
// field by field with the oldest predicted point. Both sides idle at random
// in two of three random phases, and one test holds the result side off until
// the unit stalls its input.
// ============================================================================
module circle_rasterizer_unit_test;
    import crast_pkg::*;

    localparam int CW = 12;
    localparam int RW = 8;
    localparam int PW = CW + 2;
    localparam int LIMIT_CYCLES = 400000;
    localparam int STALL_CYCLES = 300;
    localparam int TAIL_CYCLES = 32;
    localparam int MAX_REPORTS = 10;

    // One point as the unit returns it.
    typedef struct {
        logic signed [PW-1:0] x;
        logic signed [PW-1:0] y;
        logic                 plot;
        logic                 last;
    } raster_point_t;

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 push = 1'b0;
    logic                 full;
    logic                 operation = OP_STEP;
    logic [CW-1:0]        center_x = '0;
    logic [CW-1:0]        center_y = '0;
    logic [RW-1:0]        circle_radius = '0;
    logic                 fill_mode = MODE_OUTLINE;
    logic                 empty;
    logic                 pop = 1'b0;
    logic signed [PW-1:0] point_x;
    logic signed [PW-1:0] point_y;
    logic                 plot;
    logic                 last;

    // Circle state as the unit should hold it.
    logic [CW-1:0]        cur_cx = '0;
    logic [CW-1:0]        cur_cy = '0;
    logic [RW-1:0]        cur_radius = '0;
    logic                 cur_mode = MODE_OUTLINE;
    logic                 circle_active = 1'b0;
    logic [9:0]           offset_col = '0;
    logic [9:0]           offset_row = '0;
    logic signed [10:0]   decision = '0;

    raster_point_t        pending_points[$];
    int                   error_count = 0;
    int                   items_sent = 0;
    int                   cycle_count = 0;
    int                   send_idle_pct = 0;
    int                   recv_idle_pct = 0;
    logic                 stall_request = 1'b0;
    logic                 stall_active = 1'b0;

    circle_rasterizer_unit #(
        .COORD_BITS  (CW),
        .RADIUS_BITS (RW)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .operation     (operation),
        .center_x      (center_x),
        .center_y      (center_y),
        .circle_radius (circle_radius),
        .fill_mode     (fill_mode),
        .empty         (empty),
        .pop           (pop),
        .point_x       (point_x),
        .point_y       (point_y),
        .plot          (plot),
        .last          (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // The run ends at a generous cycle limit if the unit hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic void add_point(input int px, input int py, input logic p,
                                      input logic l);
        raster_point_t pt;
        pt.x = px[PW-1:0];
        pt.y = py[PW-1:0];
        pt.plot = p;
        pt.last = l;
        pending_points.push_back(pt);
    endfunction

    // Works out the points that one accepted item gives and advances the
    // circle state.
    function automatic void rasterize_item(input logic op, input logic [CW-1:0] cx,
                                           input logic [CW-1:0] cy,
                                           input logic [RW-1:0] r, input logic m);
        int a;
        int b;
        int d;
        int rr;
        int na;
        int nb;
        int dx;
        int dy;
        logic fin;
        logic end_col;
        logic hit;
        a = offset_col;
        b = offset_row;
        d = decision;
        rr = cur_radius;
        if (op == OP_START)
        begin
            cur_cx = cx;
            cur_cy = cy;
            cur_radius = r;
            cur_mode = m;
            circle_active = 1'b1;
            offset_col = '0;
            if (m == MODE_FILLED)
            begin
                offset_row = '0;
                decision = '0;
            end
            else
            begin
                offset_row = 10'(r);
                decision = 11'(int'(r) - 1);
            end
        end
        else if (!circle_active)
        begin
            add_point(0, 0, 1'b0, 1'b1);
        end
        else if (cur_mode == MODE_FILLED)
        begin
            // One candidate of the square scan; rows run fastest.
            dx = rr - a;
            dy = rr - b;
            hit = (dx * dx + dy * dy <= rr * rr);
            end_col = (b + 1 >= 2 * rr);
            fin = end_col && (a + 1 >= 2 * rr);
            add_point(int'(cur_cx) + dx, int'(cur_cy) + dy, hit, fin);
            if (fin)
                circle_active = 1'b0;
            else if (end_col)
            begin
                offset_col = 10'(a + 1);
                offset_row = '0;
            end
            else
                offset_row = 10'(b + 1);
        end
        else
        begin
            // Decision-term update, then the eight symmetric points.
            if (d >= 2 * a)
            begin
                d = d - (2 * a + 1);
                na = a + 1;
                nb = b;
            end
            else if (d < 2 * (rr - b))
            begin
                d = d + 2 * b - 1;
                na = a;
                nb = b - 1;
            end
            else
            begin
                d = d + 2 * (b - a - 1);
                na = a + 1;
                nb = b - 1;
            end
            fin = (nb < na);
            add_point(int'(cur_cx) + a, int'(cur_cy) + b, 1'b1, 1'b0);
            add_point(int'(cur_cx) + b, int'(cur_cy) + a, 1'b1, 1'b0);
            add_point(int'(cur_cx) - a, int'(cur_cy) + b, 1'b1, 1'b0);
            add_point(int'(cur_cx) - b, int'(cur_cy) + a, 1'b1, 1'b0);
            add_point(int'(cur_cx) + a, int'(cur_cy) - b, 1'b1, 1'b0);
            add_point(int'(cur_cx) + b, int'(cur_cy) - a, 1'b1, 1'b0);
            add_point(int'(cur_cx) - a, int'(cur_cy) - b, 1'b1, 1'b0);
            add_point(int'(cur_cx) - b, int'(cur_cy) - a, 1'b1, fin);
            offset_col = 10'(na);
            offset_row = 10'(nb);
            decision = 11'(d);
            if (fin)
                circle_active = 1'b0;
        end
    endfunction

    // Offers one item, waits for its transfer and records what it should give.
    // Push stays high on return so that back-to-back items need no gap.
    task automatic transfer_item(input logic op, input logic [CW-1:0] cx,
                                 input logic [CW-1:0] cy, input logic [RW-1:0] r,
                                 input logic m);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        operation <= op;
        center_x <= cx;
        center_y <= cy;
        circle_radius <= r;
        fill_mode <= m;
        @(posedge clk);
        while (full)
            @(posedge clk);
        rasterize_item(op, cx, cy, r, m);
        items_sent++;
    endtask

    // Step items carry random values in the fields that they do not use.
    task automatic send_step();
        transfer_item(OP_STEP, CW'($urandom), CW'($urandom), RW'($urandom),
                      1'($urandom));
    endtask

    // Mostly uniform centers, some close to either edge of the coordinate range.
    function automatic logic [CW-1:0] pick_center();
        case ($urandom_range(0, 9))
            0, 1:    return CW'($urandom_range(0, 15));
            2, 3:    return CW'($urandom_range(4080, 4095));
            default: return CW'($urandom);
        endcase
    endfunction

    // Lowers push and waits until every predicted point has come back.
    task automatic drain_points();
        push <= 1'b0;
        while (pending_points.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // Pops results with random stalls and checks each against the prediction.
    initial
    begin
        raster_point_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty)
            begin
                if (pending_points.size() == 0)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("unexpected point x=%0d y=%0d plot=%0b last=%0b",
                                 point_x, point_y, plot, last);
                end
                else
                begin
                    want = pending_points.pop_front();
                    if (point_x !== want.x || point_y !== want.y ||
                        plot !== want.plot || last !== want.last)
                    begin
                        error_count++;
                        if (error_count <= MAX_REPORTS)
                            $display({"point mismatch: expected x=%0d y=%0d plot=%0b ",
                                      "last=%0b, got x=%0d y=%0d plot=%0b last=%0b"},
                                     want.x, want.y, want.plot, want.last,
                                     point_x, point_y, plot, last);
                    end
                end
            end
            pop <= !stall_active && ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Holds the result side off for a fixed stretch when a test asks for it.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (stall_request)
            begin
                stall_request = 1'b0;
                stall_active <= 1'b1;
                repeat (STALL_CYCLES) @(posedge clk);
                stall_active <= 1'b0;
            end
        end
    end

    // A step with no circle, and circles of radius zero in both modes.
    task automatic test_idle_and_zero_radius();
        send_step();
        transfer_item(OP_START, 12'd100, 12'd200, 8'd0, MODE_OUTLINE);
        send_step();
        transfer_item(OP_START, 12'd4095, 12'd0, 8'd0, MODE_FILLED);
        send_step();
        send_step();
        drain_points();
    endtask

    // Extremes of center and radius; the long drawings are cut short.
    task automatic test_field_extremes();
        transfer_item(OP_START, 12'd4095, 12'd4095, 8'd1, MODE_OUTLINE);
        send_step();
        send_step();
        transfer_item(OP_START, 12'd0, 12'd0, 8'd255, MODE_OUTLINE);
        send_step();
        send_step();
        transfer_item(OP_START, 12'd0, 12'd4095, 8'd255, MODE_FILLED);
        send_step();
        send_step();
        drain_points();
    endtask

    // A new start drops a circle in progress; a finished circle leaves the unit idle.
    task automatic test_restart_while_drawing();
        transfer_item(OP_START, 12'd2048, 12'd17, 8'd3, MODE_OUTLINE);
        send_step();
        transfer_item(OP_START, 12'd4095, 12'd0, 8'd1, MODE_FILLED);
        repeat (4) send_step();
        send_step();
        drain_points();
    endtask

    // Mostly complete circles with random content, plus lone starts, idle steps
    // and circles cut short by a new start.
    task automatic test_random_drawing(input int send_pct, input int recv_pct,
                                       input int budget);
        int stop_at;
        int step_cap;
        int steps;
        int pick;
        logic m;
        logic [RW-1:0] r;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        stop_at = items_sent + budget;
        while (items_sent < stop_at)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                if ($urandom_range(0, 1) == 0)
                    send_step();
                else
                    transfer_item(OP_START, pick_center(), pick_center(),
                                  RW'($urandom_range(1, 255)), 1'($urandom));
            end
            else
            begin
                m = 1'($urandom);
                pick = $urandom_range(0, 9);
                if (m == MODE_FILLED)
                    r = (pick < 7) ? RW'($urandom_range(1, 3)) :
                        (pick < 9) ? RW'($urandom_range(4, 8)) :
                                     RW'($urandom_range(9, 255));
                else
                    r = (pick < 6) ? RW'($urandom_range(1, 15)) :
                        (pick < 9) ? RW'($urandom_range(16, 64)) :
                                     RW'($urandom_range(65, 255));
                step_cap = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 30) : 1000000;
                if (m == MODE_FILLED && r > 3)
                    step_cap = $urandom_range(1, 40);
                transfer_item(OP_START, pick_center(), pick_center(), r, m);
                steps = 0;
                while (circle_active && steps < step_cap && items_sent < stop_at)
                begin
                    send_step();
                    steps++;
                end
                if ($urandom_range(0, 3) == 0)
                    send_step();
            end
        end
        drain_points();
    endtask

    // The result side stalls while items keep coming, so the unit fills up.
    task automatic test_result_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stall_request = 1'b1;
        transfer_item(OP_START, pick_center(), pick_center(), 8'd60, MODE_OUTLINE);
        repeat (30) send_step();
        drain_points();
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_idle_and_zero_radius();
        test_field_extremes();
        test_restart_while_drawing();
        test_random_drawing(16, 45, 123);
        test_random_drawing(45, 16, 123);
        test_random_drawing(0, 0, 123);
        test_result_backpressure();
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
